[src/iirlp4_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iirlp4_pkg
// Shared types and constants of the fourth-order low-pass IIR filter.
// ----------------------------------------------------------------------------
package iirlp4_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int COEF_W       = 24;
   localparam int FRAC_BITS    = 20;
   localparam int ORDER        = 4;
   localparam int CHANNELS_DEF = 2;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = COEF_W;

   // register indexes of the configuration port
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_1 = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_2 = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_3 = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_COEF_4 = 2'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;

   // history update issued by the datapath stage
   typedef struct packed {
      logic       en;
      sample_type x;
      sample_type y;
   } hist_wr_type;

endpackage

`default_nettype wire

[src/iirlp4_hist.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iirlp4_hist
// Per-channel delay lines of the last four inputs and last four outputs.
// ----------------------------------------------------------------------------
module iirlp4_hist #(
   parameter int CHANNELS = iirlp4_pkg::CHANNELS_DEF,
   parameter int CH_W     = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [CH_W-1:0]          rd_ch,
   output iirlp4_pkg::sample_type        x_hist [iirlp4_pkg::ORDER],
   output iirlp4_pkg::sample_type        y_hist [iirlp4_pkg::ORDER],
   input  wire logic [CH_W-1:0]          wr_ch,
   input  wire iirlp4_pkg::hist_wr_type  wr
);
   import iirlp4_pkg::*;

   sample_type x_ff [CHANNELS][ORDER];
   sample_type x_in [CHANNELS][ORDER];
   sample_type y_ff [CHANNELS][ORDER];
   sample_type y_in [CHANNELS][ORDER];

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         if (wr.en && (wr_ch == CH_W'(c))) begin
            for (int k = 1; k < ORDER; k++) begin
               x_in[c][k] = x_ff[c][k-1];
               y_in[c][k] = y_ff[c][k-1];
            end
            x_in[c][0] = wr.x;
            y_in[c][0] = wr.y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            for (int k = 0; k < ORDER; k++) begin
               x_ff[c][k] <= '0;
               y_ff[c][k] <= '0;
            end
         end
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   always_comb begin
      for (int k = 0; k < ORDER; k++) begin
         x_hist[k] = x_ff[rd_ch][k];
         y_hist[k] = y_ff[rd_ch][k];
      end
   end

endmodule

`default_nettype wire

[src/iirlp4_calc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iirlp4_calc
// Filter arithmetic: binomial feedforward, feedback products, shift, saturate.
// ----------------------------------------------------------------------------
module iirlp4_calc (
   input  wire iirlp4_pkg::sample_type x,
   input  wire iirlp4_pkg::sample_type x_hist [iirlp4_pkg::ORDER],
   input  wire iirlp4_pkg::sample_type y_hist [iirlp4_pkg::ORDER],
   input  wire iirlp4_pkg::coef_type   coef   [iirlp4_pkg::ORDER],
   output iirlp4_pkg::sample_type      y,
   output logic                        clip
);
   import iirlp4_pkg::*;

   // feedforward gain is 16, so four extra bits plus one of margin
   localparam int FF_W   = SAMPLE_W + 5;
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W  = FF_W + FRAC_BITS + 3;
   localparam int Y_W    = ACC_W - FRAC_BITS;

   logic signed [FF_W-1:0]   xe;
   logic signed [FF_W-1:0]   x1e;
   logic signed [FF_W-1:0]   x2e;
   logic signed [FF_W-1:0]   x3e;
   logic signed [FF_W-1:0]   x4e;
   logic signed [FF_W-1:0]   ff;
   logic signed [PROD_W-1:0] prod [ORDER];
   logic signed [ACC_W-1:0]  fb;
   logic signed [ACC_W-1:0]  acc;
   logic signed [Y_W-1:0]    y_full;
   logic                     ovf;

   assign xe  = FF_W'(x);
   assign x1e = FF_W'(x_hist[0]);
   assign x2e = FF_W'(x_hist[1]);
   assign x3e = FF_W'(x_hist[2]);
   assign x4e = FF_W'(x_hist[3]);

   // taps 1 4 6 4 1 as shifts and adds
   assign ff = xe + (x1e <<< 2) + (x2e <<< 2) + (x2e <<< 1) + (x3e <<< 2) + x4e;

   always_comb begin
      fb = '0;
      for (int k = 0; k < ORDER; k++) begin
         prod[k] = PROD_W'(coef[k]) * PROD_W'(y_hist[k]);
         fb      = fb + ACC_W'(prod[k]);
      end
   end

   assign acc    = (ACC_W'(ff) <<< FRAC_BITS) - fb;
   // dropping the fraction bits is a floor
   assign y_full = acc[ACC_W-1:FRAC_BITS];

   // out of range when the bits above the sample sign differ from it
   assign ovf = !((&y_full[Y_W-1:SAMPLE_W-1]) || !(|y_full[Y_W-1:SAMPLE_W-1]));

   always_comb begin
      clip = ovf;
      if (!ovf) begin
         y = y_full[SAMPLE_W-1:0];
      end else if (y_full[Y_W-1]) begin
         y = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         y = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

[src/iir_lowpass_order4.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// iir_lowpass_order4
// Fourth-order direct-form-I low-pass IIR filter over interleaved channels.
// ----------------------------------------------------------------------------
// path: an accepted sample is held in the input register, its result in the output register
// throughput: one sample per cycle unless rsp_tready stalls the output; the loop from the
//   history registers through the four feedback multipliers and back has no other register
// reset: synchronous; clears coefficients, all channel history and both valid flags
module iir_lowpass_order4 #(
   parameter int CHANNELS = iirlp4_pkg::CHANNELS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [15:0]                            req_tdata,  // sample_in
   input  wire logic                                   req_tuser,  // channel_sel
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [15:0]                                 rsp_tdata,  // sample_out
   output logic                                        rsp_tuser,  // clipped
   input  wire logic                                   csr_we,
   input  wire logic [iirlp4_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [iirlp4_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import iirlp4_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   coef_type        coef_ff [ORDER];
   logic            in_valid_ff;
   logic            in_valid_in;
   sample_type      in_x_ff;
   logic [CH_W-1:0] in_ch_ff;
   logic [CH_W-1:0] in_ch_in;
   logic [CH_W:0]   sel_ext;
   logic            out_valid_ff;
   logic            out_valid_in;
   sample_type      out_y_ff;
   logic            out_clip_ff;
   logic            req_fire;
   logic            advance;
   logic            fire;
   sample_type      x_hist [ORDER];
   sample_type      y_hist [ORDER];
   sample_type      y_calc;
   logic            clip_calc;
   hist_wr_type     hist_wr;

   assign advance    = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // channel numbers past the last channel fold onto it
   assign sel_ext  = (CH_W+1)'(req_tuser);
   assign in_ch_in = (sel_ext >= (CH_W+1)'(CHANNELS)) ? CH_W'(CHANNELS - 1)
                                                     : sel_ext[CH_W-1:0];

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_x_ff  <= req_tdata;
         in_ch_ff <= in_ch_in;
      end
      if (fire) begin
         out_y_ff    <= y_calc;
         out_clip_ff <= clip_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ORDER; k++) begin
            coef_ff[k] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_COEF_1: coef_ff[0] <= csr_wdata[COEF_W-1:0];
            CSR_COEF_2: coef_ff[1] <= csr_wdata[COEF_W-1:0];
            CSR_COEF_3: coef_ff[2] <= csr_wdata[COEF_W-1:0];
            CSR_COEF_4: coef_ff[3] <= csr_wdata[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   assign hist_wr.en = fire;
   assign hist_wr.x  = in_x_ff;
   assign hist_wr.y  = y_calc;

   iirlp4_hist #(
      .CHANNELS (CHANNELS),
      .CH_W     (CH_W)
   ) u_hist (
      .clock  (clock),
      .reset  (reset),
      .rd_ch  (in_ch_ff),
      .x_hist (x_hist),
      .y_hist (y_hist),
      .wr_ch  (in_ch_ff),
      .wr     (hist_wr)
   );

   iirlp4_calc u_calc (
      .x      (in_x_ff),
      .x_hist (x_hist),
      .y_hist (y_hist),
      .coef   (coef_ff),
      .y      (y_calc),
      .clip   (clip_calc)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_y_ff;
   assign rsp_tuser  = out_clip_ff;

endmodule

`default_nettype wire
